// File: rtl/core/pvs_pkg.sv
// Package for the paletted voxel section store: default sizes, codes,
// channel word types and the controller/datapath command and status types.
// No dependencies.
package pvs_pkg;

	localparam int EDGE_DEF        = 16;
	localparam int PALETTE_MAX_DEF = 16;
	localparam int INDEX_BITS_DEF  = 4;
	localparam int ID_BITS_DEF     = 15;

	localparam int COUNT_W = 13;

	localparam logic [1:0] CMD_FILL = 2'd0;
	localparam logic [1:0] CMD_SET  = 2'd1;
	localparam logic [1:0] CMD_GET  = 2'd2;

	typedef enum logic [1:0] {
		MODE_UNIFORM = 2'd0,
		MODE_PALETTE = 2'd1,
		MODE_DIRECT  = 2'd2
	} mode_t;

	typedef struct packed {
		logic [1:0]  command;
		logic [4:0]  pos_x;
		logic [4:0]  pos_y;
		logic [4:0]  pos_z;
		logic [15:0] state_id;
		logic        state_valid;
		logic        state_air;
	} req_t;

	typedef struct packed {
		logic               status;
		logic [14:0]        read_state;
		logic [1:0]         storage_mode;
		logic [3:0]         bits_used;
		logic [4:0]         palette_count;
		logic [COUNT_W-1:0] solid_count;
	} rsp_t;

	typedef enum logic [3:0] {
		OP_NONE,
		OP_LOAD,
		OP_DECODE,
		OP_GET,
		OP_EVAL,
		OP_PROMOTE,
		OP_CONV_RD,
		OP_CONV_WR,
		OP_VOX_WR,
		OP_RESP
	} op_t;

	typedef struct packed {
		logic out_free;
		logic dec_done;
		logic dec_promote;
		logic is_get;
		logic eval_same;
		logic eval_convert;
		logic sweep_last;
	} dp_stat_t;

endpackage

// File: rtl/core/pvs_chan_if.sv
// Valid/ready channel carrying one word of type T.
// Depends on nothing; word types come from pvs_pkg at the instance.
interface pvs_chan_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/pvs_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module pvs_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;
endmodule

// File: rtl/core/pvs_ctrl.sv
// Sequencing state machine of the section store: walks each command
// through decode, voxel access, sweeps and response. Depends on pvs_pkg.
module pvs_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	input  pvs_pkg::dp_stat_t stat,
	output pvs_pkg::op_t      op
);
	import pvs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECODE,
		ST_GET,
		ST_EVAL,
		ST_PROMOTE,
		ST_CONV_RD,
		ST_CONV_WR,
		ST_VOX_WR,
		ST_RESP
	} state_t;

	state_t state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (req_valid) state_q <= ST_DECODE;
				end
				ST_DECODE: begin
					if (stat.dec_done) state_q <= ST_RESP;
					else if (stat.dec_promote) state_q <= ST_PROMOTE;
					else if (stat.is_get) state_q <= ST_GET;
					else state_q <= ST_EVAL;
				end
				ST_GET: state_q <= ST_RESP;
				ST_EVAL: begin
					if (stat.eval_same) state_q <= ST_RESP;
					else if (stat.eval_convert) state_q <= ST_CONV_RD;
					else state_q <= ST_VOX_WR;
				end
				ST_PROMOTE: begin
					if (stat.sweep_last) state_q <= ST_VOX_WR;
				end
				ST_CONV_RD: state_q <= ST_CONV_WR;
				ST_CONV_WR: begin
					state_q <= stat.sweep_last ? ST_VOX_WR : ST_CONV_RD;
				end
				ST_VOX_WR: state_q <= ST_RESP;
				ST_RESP: begin
					if (stat.out_free) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign req_ready = (state_q == ST_IDLE);

	always_comb begin
		case (state_q)
			ST_IDLE:    op = req_valid ? OP_LOAD : OP_NONE;
			ST_DECODE:  op = OP_DECODE;
			ST_GET:     op = OP_GET;
			ST_EVAL:    op = OP_EVAL;
			ST_PROMOTE: op = OP_PROMOTE;
			ST_CONV_RD: op = OP_CONV_RD;
			ST_CONV_WR: op = OP_CONV_WR;
			ST_VOX_WR:  op = OP_VOX_WR;
			ST_RESP:    op = OP_RESP;
			default:    op = OP_NONE;
		endcase
	end
endmodule

// File: rtl/core/pvs_dpath.sv
// Datapath of the section store: command word, mode and palette registers,
// voxel RAM ({air, slot} per voxel), solid counter and response register.
// Depends on pvs_pkg and pvs_ram.
module pvs_dpath #(
	parameter int EDGE        = pvs_pkg::EDGE_DEF,
	parameter int PALETTE_MAX = pvs_pkg::PALETTE_MAX_DEF,
	parameter int INDEX_BITS  = pvs_pkg::INDEX_BITS_DEF,
	parameter int ID_BITS     = pvs_pkg::ID_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  pvs_pkg::op_t      op,
	output pvs_pkg::dp_stat_t stat,
	input  pvs_pkg::req_t     req_data,
	output logic              rsp_valid,
	output pvs_pkg::rsp_t     rsp_data,
	input  logic              rsp_ready
);
	import pvs_pkg::*;

	localparam int VOLUME  = EDGE * EDGE * EDGE;
	localparam int VOX_W   = $clog2(VOLUME);
	localparam int ENTRY_W = ID_BITS + 1;
	localparam int UW      = $clog2(PALETTE_MAX + 1);
	localparam int PAL_CAP = (PALETTE_MAX < (1 << INDEX_BITS)) ? PALETTE_MAX : (1 << INDEX_BITS);
	localparam logic [32:0] ID_MAX = (33'd1 << ID_BITS) - 33'd1;

	req_t                item_q;
	mode_t               mode_q;
	logic [ID_BITS-1:0]  uniform_q;
	logic                uair_q;
	logic [ID_BITS-1:0]  pal_q [PALETTE_MAX];
	logic [UW-1:0]       used_q;
	logic [COUNT_W-1:0]  count_q;
	logic                err_q;
	logic [ID_BITS-1:0]  rd_q;
	logic                old_air_q;
	logic [VOX_W-1:0]    cnt_q;
	logic                out_valid_q;
	rsp_t                out_q;

	logic                ram_we;
	logic [VOX_W-1:0]    ram_waddr;
	logic [VOX_W-1:0]    ram_raddr;
	logic [ENTRY_W-1:0]  ram_wdata;
	logic [ENTRY_W-1:0]  ram_rdata;

	logic                id_ok;
	logic                coords_ok;
	logic [VOX_W-1:0]    idx;
	logic [ID_BITS-1:0]  item_id;
	logic                is_fill;
	logic                is_set;
	logic                is_get;
	logic                dec_err;
	logic [ID_BITS-1:0]  rd_slot;
	logic                rd_air;
	logic [INDEX_BITS-1:0] rd_ix;
	logic [ID_BITS-1:0]  pal_rd;
	logic [ID_BITS-1:0]  old_id;
	logic                found;
	logic [INDEX_BITS-1:0] loc;
	logic                full;
	logic                out_free;
	logic                sweep_last;
	logic [3:0]          bits_now;

	assign item_id   = ID_BITS'(item_q.state_id);
	assign id_ok     = item_q.state_valid && (33'(item_q.state_id) <= ID_MAX);
	assign coords_ok = (6'(item_q.pos_x) < 6'(EDGE)) && (6'(item_q.pos_y) < 6'(EDGE))
		&& (6'(item_q.pos_z) < 6'(EDGE));
	assign idx = VOX_W'((int'(item_q.pos_y) * EDGE + int'(item_q.pos_z)) * EDGE
		+ int'(item_q.pos_x));
	assign is_fill = (item_q.command == CMD_FILL);
	assign is_set  = (item_q.command == CMD_SET);
	assign is_get  = (item_q.command == CMD_GET);

	always_comb begin
		if (is_fill) dec_err = !id_ok;
		else if (is_set) dec_err = !id_ok || !coords_ok;
		else if (is_get) dec_err = !coords_ok;
		else dec_err = 1'b1;
	end

	assign rd_slot = ram_rdata[ID_BITS-1:0];
	assign rd_air  = ram_rdata[ID_BITS];
	assign rd_ix   = rd_slot[INDEX_BITS-1:0];

	// stale or out-of-table indices read as zero
	always_comb begin
		pal_rd = '0;
		for (int i = 0; i < PALETTE_MAX; i++) begin
			if (32'(rd_ix) == i && i < int'(used_q)) pal_rd = pal_q[i];
		end
	end

	always_comb begin
		case (mode_q)
			MODE_UNIFORM: old_id = uniform_q;
			MODE_PALETTE: old_id = pal_rd;
			MODE_DIRECT:  old_id = rd_slot;
			default:      old_id = '0;
		endcase
	end

	always_comb begin
		found = 1'b0;
		loc   = '0;
		for (int i = 0; i < PALETTE_MAX; i++) begin
			if (!found && i < int'(used_q) && pal_q[i] == item_id) begin
				found = 1'b1;
				loc   = INDEX_BITS'(i);
			end
		end
	end

	assign full       = (int'(used_q) >= PAL_CAP);
	assign sweep_last = (int'(cnt_q) == VOLUME - 1);
	assign out_free   = !out_valid_q || rsp_ready;

	assign stat.out_free     = out_free;
	assign stat.dec_done     = dec_err || is_fill || (is_get && mode_q == MODE_UNIFORM)
		|| (mode_q == MODE_UNIFORM && item_id == uniform_q);
	assign stat.dec_promote  = is_set && mode_q == MODE_UNIFORM && item_id != uniform_q;
	assign stat.is_get       = is_get;
	assign stat.eval_same    = (old_id == item_id);
	assign stat.eval_convert = (mode_q == MODE_PALETTE) && !found && full;
	assign stat.sweep_last   = sweep_last;

	// voxel RAM ports
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = idx;
		ram_wdata = {item_q.state_air, (mode_q == MODE_DIRECT) ? item_id : ID_BITS'(loc)};
		ram_raddr = (op == OP_CONV_RD) ? cnt_q : idx;
		case (op)
			OP_PROMOTE: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = {uair_q, {ID_BITS{1'b0}}};
			end
			OP_CONV_WR: begin
				ram_we    = 1'b1;
				ram_waddr = cnt_q;
				ram_wdata = {rd_air, pal_rd};
			end
			OP_VOX_WR: ram_we = 1'b1;
			default: ram_we = 1'b0;
		endcase
	end

	pvs_ram #(.WIDTH(ENTRY_W), .DEPTH(VOLUME)) u_vox_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		case (mode_q)
			MODE_UNIFORM: bits_now = 4'd0;
			MODE_PALETTE: bits_now = 4'(INDEX_BITS);
			MODE_DIRECT:  bits_now = 4'(ID_BITS);
			default:      bits_now = 4'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q      <= MODE_UNIFORM;
			uniform_q   <= '0;
			uair_q      <= 1'b0;
			used_q      <= '0;
			count_q     <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < PALETTE_MAX; i++) pal_q[i] <= '0;
		end else begin
			if (rsp_ready) out_valid_q <= 1'b0;
			case (op)
				OP_DECODE: begin
					if (is_fill && !dec_err) begin
						mode_q    <= MODE_UNIFORM;
						uniform_q <= item_id;
						uair_q    <= item_q.state_air;
						used_q    <= '0;
						count_q   <= item_q.state_air ? '0 : COUNT_W'(VOLUME);
						for (int i = 0; i < PALETTE_MAX; i++) pal_q[i] <= '0;
					end else if (stat.dec_promote && !dec_err) begin
						pal_q[0] <= uniform_q;
						pal_q[1] <= item_id;
						used_q   <= UW'(2);
						mode_q   <= MODE_PALETTE;
					end
				end
				OP_EVAL: begin
					if (!stat.eval_same && mode_q == MODE_PALETTE && !found && !full) begin
						for (int i = 0; i < PALETTE_MAX; i++) begin
							if (i == int'(used_q)) pal_q[i] <= item_id;
						end
						used_q <= used_q + UW'(1);
					end
				end
				OP_CONV_WR: begin
					if (sweep_last) begin
						mode_q <= MODE_DIRECT;
						used_q <= '0;
						for (int i = 0; i < PALETTE_MAX; i++) pal_q[i] <= '0;
					end
				end
				OP_VOX_WR: begin
					if (old_air_q != item_q.state_air) begin
						count_q <= item_q.state_air ? count_q - COUNT_W'(1)
							: count_q + COUNT_W'(1);
					end
				end
				OP_RESP: begin
					if (out_free) out_valid_q <= 1'b1;
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (op)
			OP_LOAD: item_q <= req_data;
			OP_DECODE: begin
				err_q     <= dec_err;
				rd_q      <= (is_get && mode_q == MODE_UNIFORM) ? uniform_q : '0;
				old_air_q <= uair_q;
				cnt_q     <= '0;
			end
			OP_GET: rd_q <= old_id;
			OP_EVAL: begin
				old_air_q <= rd_air;
				cnt_q     <= '0;
			end
			OP_PROMOTE: cnt_q <= cnt_q + VOX_W'(1);
			OP_CONV_WR: cnt_q <= cnt_q + VOX_W'(1);
			OP_RESP: begin
				if (out_free) begin
					out_q.status        <= err_q;
					out_q.read_state    <= 15'(rd_q);
					out_q.storage_mode  <= mode_q;
					out_q.bits_used     <= bits_now;
					out_q.palette_count <= 5'(used_q);
					out_q.solid_count   <= count_q;
				end
			end
			default: ;
		endcase
	end

	assign rsp_valid = out_valid_q;
	assign rsp_data  = out_q;
endmodule

// File: rtl/core/paletted_voxel_section_store_core.sv
// Top level of the paletted voxel section store.
// Depends on pvs_pkg, pvs_chan_if, pvs_ctrl, pvs_dpath (and pvs_ram below it).
//
// Usage: command words enter on req (fill, set, get); every word yields one
// response word on rsp with status, read id, mode, bits per voxel, palette
// count and solid count after the command.
// A set that turns the uniform section into a palette first writes every voxel
// entry, one per cycle. A set that overflows the palette converts all voxels to
// direct ids, reading and then writing each voxel entry. One word is processed
// at a time; the next word is accepted right after the response is loaded.
// Reset: section is uniform id 0, empty palette, solid count 0; the voxel
// RAM needs no clearing pass.
// A stalled receiver: the response sits in the output register; the next
// word is still accepted and processed up to its response, then waits.
module paletted_voxel_section_store_core #(
	parameter int EDGE        = pvs_pkg::EDGE_DEF,
	parameter int PALETTE_MAX = pvs_pkg::PALETTE_MAX_DEF,
	parameter int INDEX_BITS  = pvs_pkg::INDEX_BITS_DEF,
	parameter int ID_BITS     = pvs_pkg::ID_BITS_DEF
) (
	input logic        clk,
	input logic        arst_n,
	pvs_chan_if.sink   req,
	pvs_chan_if.source rsp
);
	import pvs_pkg::*;

	op_t      op;
	dp_stat_t stat;
	logic     ready;

	pvs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (ready),
		.stat      (stat),
		.op        (op)
	);

	pvs_dpath #(
		.EDGE        (EDGE),
		.PALETTE_MAX (PALETTE_MAX),
		.INDEX_BITS  (INDEX_BITS),
		.ID_BITS     (ID_BITS)
	) u_dpath (
		.clk       (clk),
		.arst_n    (arst_n),
		.op        (op),
		.stat      (stat),
		.req_data  (req.data),
		.rsp_valid (rsp.valid),
		.rsp_data  (rsp.data),
		.rsp_ready (rsp.ready)
	);

	assign req.ready = ready;
endmodule

// File: verif/pvs_section_checker.sv
// Response checker for the paletted voxel section store: predicts each response word
// from the accepted request words and compares it field by field.
// Depends on pvs_pkg.
module pvs_section_checker
	import pvs_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req_word,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp_word,
	output int   fail_count,
	output int   pending
);

	localparam int VOL = 4096;

	mode_t       sec_mode;
	logic [14:0] uni_id;
	logic [14:0] pal[16];
	int          pal_n;
	int          solid;
	logic [3:0]  pal_idx[VOL];
	logic [14:0] dir_id[VOL];
	bit          air_bit[VOL];
	rsp_t        expected_rsp[$];

	function automatic logic [14:0] voxel_state(int i);
		if (sec_mode == MODE_UNIFORM) begin
			return uni_id;
		end
		if (sec_mode == MODE_DIRECT) begin
			return dir_id[i];
		end
		if (pal_idx[i] >= pal_n) begin
			return '0;
		end
		return pal[pal_idx[i]];
	endfunction

	function automatic int pal_lookup(logic [14:0] id);
		for (int i = 0; i < pal_n; i++) begin
			if (pal[i] == id) begin
				return i;
			end
		end
		return -1;
	endfunction

	task automatic predict_word(input req_t w);
		rsp_t        e;
		bit          ok_id;
		bit          ok_pos;
		int          vi;
		int          loc;
		logic [14:0] id;
		ok_id  = w.state_valid && (w.state_id <= 16'h7fff);
		ok_pos = (w.pos_x < 16) && (w.pos_y < 16) && (w.pos_z < 16);
		vi     = ok_pos ? (int'(w.pos_y) * 16 + int'(w.pos_z)) * 16 + int'(w.pos_x) : 0;
		id     = w.state_id[14:0];
		e      = '0;
		case (w.command)
			CMD_FILL: begin
				if (!ok_id) begin
					e.status = 1'b1;
				end else begin
					sec_mode = MODE_UNIFORM;
					uni_id   = id;
					pal_n    = 0;
					foreach (pal[i]) pal[i] = '0;
					foreach (air_bit[i]) air_bit[i] = w.state_air;
					solid = w.state_air ? 0 : VOL;
				end
			end
			CMD_SET: begin
				if (!ok_pos || !ok_id) begin
					e.status = 1'b1;
				end else if (voxel_state(vi) != id) begin
					if (sec_mode == MODE_UNIFORM) begin
						pal[0]   = uni_id;
						pal[1]   = id;
						pal_n    = 2;
						sec_mode = MODE_PALETTE;
						foreach (pal_idx[i]) pal_idx[i] = '0;
					end else if (sec_mode == MODE_PALETTE && pal_lookup(id) < 0) begin
						if (pal_n < 16) begin
							pal[pal_n] = id;
							pal_n++;
						end else begin
							for (int i = 0; i < VOL; i++) dir_id[i] = voxel_state(i);
							sec_mode = MODE_DIRECT;
							pal_n    = 0;
							foreach (pal[i]) pal[i] = '0;
						end
					end
					if (sec_mode == MODE_DIRECT) begin
						dir_id[vi] = id;
					end else begin
						loc         = pal_lookup(id);
						pal_idx[vi] = (loc < 0) ? 4'd0 : 4'(loc);
					end
					if (air_bit[vi] != w.state_air) begin
						solid = w.state_air ? solid - 1 : solid + 1;
					end
					air_bit[vi] = w.state_air;
				end
			end
			CMD_GET: begin
				if (!ok_pos) begin
					e.status     = 1'b1;
					e.read_state = (sec_mode == MODE_UNIFORM) ? uni_id : '0;
				end else begin
					e.read_state = voxel_state(vi);
				end
			end
			default: e.status = 1'b1;
		endcase
		e.storage_mode  = sec_mode;
		e.bits_used     = (sec_mode == MODE_UNIFORM) ? 4'd0 :
		                  (sec_mode == MODE_PALETTE) ? 4'd4 : 4'd15;
		e.palette_count = 5'(pal_n);
		e.solid_count   = COUNT_W'(solid);
		expected_rsp.push_back(e);
	endtask

	task automatic report(string what, int exp_v, int act_v);
		if (fail_count < 10) begin
			$display("mismatch %s: expected %0d got %0d", what, exp_v, act_v);
		end
		fail_count++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		rsp_t e;
		if (!arst_n) begin
			sec_mode   = MODE_UNIFORM;
			uni_id     = '0;
			pal_n      = 0;
			solid      = 0;
			fail_count = 0;
			pending    = 0;
			foreach (pal[i]) pal[i] = '0;
			expected_rsp.delete();
		end else begin
			if (req_valid && req_ready) begin
				predict_word(req_word);
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_rsp.size() == 0) begin
					report("unexpected word", 0, 1);
				end else begin
					e = expected_rsp.pop_front();
					if (rsp_word.status != e.status)
						report("status", e.status, rsp_word.status);
					if (rsp_word.read_state != e.read_state)
						report("read_state", e.read_state, rsp_word.read_state);
					if (rsp_word.storage_mode != e.storage_mode)
						report("storage_mode", e.storage_mode, rsp_word.storage_mode);
					if (rsp_word.bits_used != e.bits_used)
						report("bits_used", e.bits_used, rsp_word.bits_used);
					if (rsp_word.palette_count != e.palette_count)
						report("palette_count", e.palette_count, rsp_word.palette_count);
					if (rsp_word.solid_count != e.solid_count)
						report("solid_count", e.solid_count, rsp_word.solid_count);
				end
			end
			pending = expected_rsp.size();
		end
	end

endmodule

// File: verif/tb_paletted_voxel_section_store_core.sv
// Testbench top for paletted_voxel_section_store_core: directed and random command
// words with idle and stall phases; pvs_section_checker does the checking.
// Depends on pvs_pkg, pvs_chan_if, the core and pvs_section_checker.
module tb_paletted_voxel_section_store_core;
	import pvs_pkg::*;

	localparam int WATCHDOG = 60000;

	logic clk;
	logic arst_n;
	int   fail_count;
	int   pending;
	int   quiet_cycles;
	int   send_idle;
	int   recv_stall;
	logic [15:0] id_pool[24];
	int   pool_n;

	pvs_chan_if #(.T(req_t)) req_ch ();
	pvs_chan_if #(.T(rsp_t)) rsp_ch ();

	paletted_voxel_section_store_core u_top (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_ch.sink),
		.rsp   (rsp_ch.source)
	);

	pvs_section_checker u_chk (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_ch.valid),
		.req_ready (req_ch.ready),
		.req_word  (req_ch.data),
		.rsp_valid (rsp_ch.valid),
		.rsp_ready (rsp_ch.ready),
		.rsp_word  (rsp_ch.data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
	end
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= recv_stall);
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles >= WATCHDOG) begin
			$display("tb_paletted_voxel_section_store_core failed");
			$finish;
		end
	end

	task automatic send_word(input logic [1:0] cmd, input logic [4:0] x, input logic [4:0] y,
		input logic [4:0] z, input logic [15:0] id, input logic vld, input logic air);
		req_t w;
		w = '{command: cmd, pos_x: x, pos_y: y, pos_z: z, state_id: id,
		      state_valid: vld, state_air: air};
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		do @(posedge clk); while (!req_ch.ready);
		if ($urandom_range(99) < send_idle) begin
			req_ch.valid <= 1'b0;
			while ($urandom_range(99) < send_idle) @(posedge clk);
			@(posedge clk);
		end
	endtask

	task automatic new_pool();
		pool_n = $urandom_range(24, 2);
		foreach (id_pool[i]) id_pool[i] = 16'($urandom_range(16'h7fff));
	endtask

	task automatic random_word();
		logic [15:0] id;
		int          r;
		r  = $urandom_range(99);
		id = id_pool[$urandom_range(pool_n - 1)];
		if (r < 10) begin
			send_word(2'($urandom), 5'($urandom), 5'($urandom), 5'($urandom), 16'($urandom),
				1'($urandom), 1'($urandom));
		end else if (r < 13) begin
			new_pool();
			send_word(CMD_FILL, 5'($urandom), 5'($urandom), 5'($urandom), id_pool[0], 1'b1,
				1'($urandom));
		end else if (r < 60) begin
			send_word(CMD_SET, 5'($urandom_range(15)), 5'($urandom_range(15)),
				5'($urandom_range(15)), id, 1'b1, 1'($urandom));
		end else begin
			send_word(CMD_GET, 5'($urandom_range(15)), 5'($urandom_range(15)),
				5'($urandom_range(15)), 16'($urandom), 1'($urandom), 1'($urandom));
		end
	endtask

	initial begin
		arst_n       = 1'b0;
		req_ch.valid = 1'b0;
		req_ch.data  = '0;
		rsp_ch.ready = 1'b0;
		quiet_cycles = 0;
		send_idle    = 0;
		recv_stall   = 0;
		new_pool();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_word(CMD_FILL, 0, 0, 0, 16'd0, 1'b1, 1'b1);
		send_word(CMD_GET, 0, 0, 0, 16'd0, 1'b0, 1'b0);
		send_word(CMD_GET, 15, 15, 15, 16'hffff, 1'b1, 1'b1);
		send_word(CMD_GET, 16, 0, 0, 16'd0, 1'b1, 1'b0);
		send_word(CMD_SET, 0, 31, 0, 16'd5, 1'b1, 1'b0);
		send_word(CMD_SET, 0, 0, 16, 16'd5, 1'b1, 1'b0);
		send_word(CMD_SET, 1, 1, 1, 16'd5, 1'b0, 1'b0);
		send_word(CMD_SET, 1, 1, 1, 16'h8000, 1'b1, 1'b0);
		send_word(CMD_FILL, 0, 0, 0, 16'hffff, 1'b1, 1'b0);
		send_word(2'd3, 0, 0, 0, 16'd0, 1'b1, 1'b0);
		send_word(CMD_FILL, 31, 31, 31, 16'h7fff, 1'b1, 1'b0);
		send_word(CMD_SET, 3, 4, 5, 16'h7fff, 1'b1, 1'b0);
		send_word(CMD_SET, 0, 0, 0, 16'd0, 1'b1, 1'b1);
		send_word(CMD_GET, 0, 0, 0, 16'd0, 1'b1, 1'b0);
		send_word(CMD_GET, 1, 0, 0, 16'd0, 1'b1, 1'b0);
		send_word(CMD_GET, 0, 0, 31, 16'd0, 1'b1, 1'b0);
		for (int i = 1; i <= 16; i++) begin
			send_word(CMD_SET, 5'(i - 1), 15, 2, 16'(100 + i), 1'b1, 1'($urandom));
		end
		send_word(CMD_GET, 15, 15, 2, 16'd0, 1'b1, 1'b0);
		send_word(CMD_GET, 0, 0, 0, 16'd0, 1'b1, 1'b0);
		send_word(CMD_GET, 16, 16, 16, 16'd0, 1'b1, 1'b0);
		send_word(CMD_FILL, 0, 0, 0, 16'd9, 1'b0, 1'b0);

		for (int ph = 0; ph < 8; ph++) begin
			case (ph % 4)
				0: begin send_idle = 0;  recv_stall = 0;  end
				1: begin send_idle = 67; recv_stall = 0;  end
				2: begin send_idle = 0;  recv_stall = 67; end
				default: begin send_idle = 28; recv_stall = 28; end
			endcase
			repeat (225) random_word();
		end

		req_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb_paletted_voxel_section_store_core passed");
		end else begin
			$display("tb_paletted_voxel_section_store_core failed");
		end
		$finish;
	end

endmodule
